// File: hw/rtl/c8ie_pkg.sv
// Shared types, opcode codes and constants for the CHIP-8 instruction executor.
package c8ie_pkg;

   localparam int ADDR_W          = 12;
   localparam int STACK_DEPTH_DEF = 16;
   localparam logic [ADDR_W-1:0] START_ADDRESS_RESET = 12'h200;

   localparam logic CMD_EXEC = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Instruction groups (opcode bits 15:12)
   localparam logic [3:0] GRP_SYS     = 4'h0;
   localparam logic [3:0] GRP_JP      = 4'h1;
   localparam logic [3:0] GRP_CALL    = 4'h2;
   localparam logic [3:0] GRP_SE_IMM  = 4'h3;
   localparam logic [3:0] GRP_SNE_IMM = 4'h4;
   localparam logic [3:0] GRP_SE_REG  = 4'h5;
   localparam logic [3:0] GRP_LD_IMM  = 4'h6;
   localparam logic [3:0] GRP_ADD_IMM = 4'h7;
   localparam logic [3:0] GRP_ALU     = 4'h8;
   localparam logic [3:0] GRP_SNE_REG = 4'h9;
   localparam logic [3:0] GRP_LD_I    = 4'hA;
   localparam logic [3:0] GRP_JP_V0   = 4'hB;
   localparam logic [3:0] GRP_RND     = 4'hC;
   localparam logic [3:0] GRP_MISC    = 4'hF;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   // ALU group functions (opcode bits 3:0)
   localparam logic [3:0] ALU_LD   = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // Misc group functions (opcode bits 7:0)
   localparam logic [7:0] FN_LD_VX_DT = 8'h07;
   localparam logic [7:0] FN_LD_DT    = 8'h15;
   localparam logic [7:0] FN_LD_ST    = 8'h18;
   localparam logic [7:0] FN_ADD_I    = 8'h1E;

   localparam logic [3:0]  REG_V0     = 4'h0;
   localparam logic [3:0]  REG_FLAG   = 4'hF;
   localparam logic [16:0] I_OVF_LIMIT = 17'h00FFF;

   typedef struct packed {
      logic        command;
      logic [15:0] opcode;
      logic [7:0]  random_byte;
      logic [7:0]  vx;
      logic [7:0]  vb;      // VY, or V0 for the indexed jump
   } exec_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] pc;
      logic [15:0]       index;
      logic [7:0]        delay;
      logic [7:0]        sound;
      logic              stack_full;
      logic              stack_empty;
      logic [ADDR_W-1:0] stack_top;
   } arch_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] next_pc;
      logic [15:0]       index_next;
      logic [7:0]        delay_next;
      logic [7:0]        sound_next;
      logic              reg_written;
      logic [3:0]        reg_number;
      logic [7:0]        reg_value;
      logic              clear_screen;
      logic              stack_error;
      logic              push;
      logic              pop;
      logic [ADDR_W-1:0] push_addr;
      logic              rf_we;
      logic [3:0]        rf_waddr;
      logic [7:0]        rf_wdata;
      logic              vf_we;
      logic [7:0]        vf_wdata;
   } exec_result_type;

endpackage

// File: hw/rtl/c8ie_exec.sv
// Combinational execute logic: decodes one opcode or timer tick against the current state.
module c8ie_exec (
   input  c8ie_pkg::exec_item_type   item,
   input  c8ie_pkg::arch_state_type  st,
   output c8ie_pkg::exec_result_type res
);

   logic [3:0]  grp;
   logic [3:0]  x;
   logic [3:0]  fn;
   logic [7:0]  nn;
   logic [11:0] nnn;
   logic [11:0] pc_plus2;
   logic [11:0] pc_plus4;
   logic [8:0]  add9;
   logic [16:0] isum;
   logic        vx_we;
   logic [7:0]  vx_val;
   logic        flag_we;
   logic [7:0]  flag_val;
   logic        wr;
   logic [3:0]  wnum;

   assign grp      = item.opcode[15:12];
   assign x        = item.opcode[11:8];
   assign fn       = item.opcode[3:0];
   assign nn       = item.opcode[7:0];
   assign nnn      = item.opcode[11:0];
   assign pc_plus2 = st.pc + 12'd2;
   assign pc_plus4 = st.pc + 12'd4;
   assign add9     = {1'b0, item.vx} + {1'b0, item.vb};
   assign isum     = {1'b0, st.index} + {9'd0, item.vx};

   always_comb begin
      res            = '0;
      res.next_pc    = pc_plus2;
      res.index_next = st.index;
      res.delay_next = st.delay;
      res.sound_next = st.sound;
      res.push_addr  = pc_plus2;
      vx_we          = 1'b0;
      vx_val         = 8'd0;
      flag_we        = 1'b0;
      flag_val       = 8'd0;
      wr             = 1'b0;
      wnum           = x;

      if (item.command == c8ie_pkg::CMD_TICK) begin
         res.next_pc = st.pc;
         if (st.sound != 8'd0) res.sound_next = st.sound - 8'd1;
         if (st.delay != 8'd0) res.delay_next = st.delay - 8'd1;
      end else begin
         case (grp)
            c8ie_pkg::GRP_SYS: begin
               if (item.opcode == c8ie_pkg::OP_CLS) begin
                  res.clear_screen = 1'b1;
               end else if (item.opcode == c8ie_pkg::OP_RET) begin
                  if (st.stack_empty) begin
                     res.stack_error = 1'b1;
                  end else begin
                     res.pop     = 1'b1;
                     res.next_pc = st.stack_top;
                  end
               end
            end
            c8ie_pkg::GRP_JP: res.next_pc = nnn;
            c8ie_pkg::GRP_CALL: begin
               if (st.stack_full) begin
                  res.stack_error = 1'b1;
               end else begin
                  res.push    = 1'b1;
                  res.next_pc = nnn;
               end
            end
            c8ie_pkg::GRP_SE_IMM:  if (item.vx == nn) res.next_pc = pc_plus4;
            c8ie_pkg::GRP_SNE_IMM: if (item.vx != nn) res.next_pc = pc_plus4;
            c8ie_pkg::GRP_SE_REG:  if (item.vx == item.vb) res.next_pc = pc_plus4;
            c8ie_pkg::GRP_SNE_REG: if (item.vx != item.vb) res.next_pc = pc_plus4;
            c8ie_pkg::GRP_LD_IMM: begin
               vx_we  = 1'b1;
               vx_val = nn;
               wr     = 1'b1;
            end
            c8ie_pkg::GRP_ADD_IMM: begin
               vx_we  = 1'b1;
               vx_val = item.vx + nn;
               wr     = 1'b1;
            end
            c8ie_pkg::GRP_ALU: begin
               wr    = 1'b1;
               vx_we = 1'b1;
               case (fn)
                  c8ie_pkg::ALU_LD:  vx_val = item.vb;
                  c8ie_pkg::ALU_OR:  vx_val = item.vx | item.vb;
                  c8ie_pkg::ALU_AND: vx_val = item.vx & item.vb;
                  c8ie_pkg::ALU_XOR: vx_val = item.vx ^ item.vb;
                  c8ie_pkg::ALU_ADD: begin
                     vx_val   = add9[7:0];
                     flag_we  = 1'b1;
                     flag_val = {7'd0, add9[8]};
                  end
                  c8ie_pkg::ALU_SUB: begin
                     vx_val   = item.vx - item.vb;
                     flag_we  = 1'b1;
                     flag_val = {7'd0, item.vx >= item.vb};
                  end
                  c8ie_pkg::ALU_SHR: begin
                     vx_val   = {1'b0, item.vx[7:1]};
                     flag_we  = 1'b1;
                     flag_val = {7'd0, item.vx[0]};
                  end
                  c8ie_pkg::ALU_SUBN: begin
                     vx_val   = item.vb - item.vx;
                     flag_we  = 1'b1;
                     flag_val = {7'd0, item.vb >= item.vx};
                  end
                  c8ie_pkg::ALU_SHL: begin
                     vx_val   = {item.vx[6:0], 1'b0};
                     flag_we  = 1'b1;
                     flag_val = {7'd0, item.vx[7]};
                  end
                  default: begin
                     wr    = 1'b0;
                     vx_we = 1'b0;
                  end
               endcase
            end
            c8ie_pkg::GRP_LD_I:  res.index_next = {4'd0, nnn};
            c8ie_pkg::GRP_JP_V0: res.next_pc = nnn + {4'd0, item.vb};
            c8ie_pkg::GRP_RND: begin
               vx_we  = 1'b1;
               vx_val = item.random_byte & nn;
               wr     = 1'b1;
            end
            c8ie_pkg::GRP_MISC: begin
               case (nn)
                  c8ie_pkg::FN_LD_VX_DT: begin
                     vx_we  = 1'b1;
                     vx_val = st.delay;
                     wr     = 1'b1;
                  end
                  c8ie_pkg::FN_LD_DT: res.delay_next = item.vx;
                  c8ie_pkg::FN_LD_ST: res.sound_next = item.vx;
                  c8ie_pkg::FN_ADD_I: begin
                     res.index_next = isum[15:0];
                     flag_we        = 1'b1;
                     flag_val       = {7'd0, isum > c8ie_pkg::I_OVF_LIMIT};
                     wr             = 1'b1;
                     wnum           = c8ie_pkg::REG_FLAG;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      // VF is held apart from the register file; the flag wins over a VX write to VF
      res.rf_we    = vx_we && (x != c8ie_pkg::REG_FLAG);
      res.rf_waddr = x;
      res.rf_wdata = vx_val;
      res.vf_we    = (vx_we && (x == c8ie_pkg::REG_FLAG)) || flag_we;
      res.vf_wdata = flag_we ? flag_val : vx_val;

      res.reg_written = wr;
      res.reg_number  = wr ? wnum : 4'd0;
      if (!wr)                           res.reg_value = 8'd0;
      else if (wnum == c8ie_pkg::REG_FLAG) res.reg_value = res.vf_wdata;
      else                               res.reg_value = vx_val;
   end

endmodule

// File: hw/rtl/chip8_instruction_executor_core.sv
// Top level of the CHIP-8 instruction executor: state, register file, return stack, handshakes.
//
// Request channel (req_valid/req_ready): one transaction is either an opcode to
// execute (req_command = 0) with the random byte for CXNN, or one 60 Hz timer
// tick (req_command = 1). Response channel (rsp_valid/rsp_ready): exactly one
// transaction per request, in order, carrying next pc, index, the register
// write, clear-screen, sound state and the stack error flag.
// The request is captured in an input register (VX and VY/V0 are read
// from the register file there, forwarded from the executing item), executed
// from there once the response register is free or being taken, and held in
// the response register, which drives rsp_valid. Throughput is one transaction per
// cycle while the receiver does not stall; the state loop closes through the execute logic.
// When the receiver stalls, the response register holds and the input register
// still takes one more request; after that req_ready drops until rsp_ready.
// Reset (synchronous): pc = 0x200, index, V0..VF, stack depth and timers zero.
// A csr write loads the program counter directly; write only while idle.
// Return stack: STACK_DEPTH entries with top and next-to-top kept in registers.
module chip8_instruction_executor_core #(
   parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_opcode,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_next_pc,
   output logic [15:0] rsp_index_value,
   output logic        rsp_reg_written,
   output logic [3:0]  rsp_reg_number,
   output logic [7:0]  rsp_reg_value,
   output logic        rsp_clear_screen,
   output logic        rsp_sound_on,
   output logic        rsp_stack_error
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W   = $clog2(STACK_DEPTH);

   // Input stage
   logic                      in_valid_ff;
   c8ie_pkg::exec_item_type   item_ff;
   // Architectural state
   logic [11:0]               pc_ff;
   logic [15:0]               index_ff;
   logic [7:0]                delay_ff;
   logic [7:0]                sound_ff;
   logic [DEPTH_W-1:0]        depth_ff;
   logic [7:0]                vf_ff;
   logic [7:0]                vf_in;
   logic [14:0]               rf_valid_ff;
   logic [7:0]                rf_mem [15];
   logic [11:0]               stack_mem [STACK_DEPTH];
   logic [11:0]               top_ff;
   logic [11:0]               below_ff;
   // Response register
   logic                      rsp_valid_ff;
   c8ie_pkg::exec_result_type rsp_ff;

   c8ie_pkg::arch_state_type  st;
   c8ie_pkg::exec_result_type ex;
   logic                      exec_fire;
   logic                      req_fire;
   logic [3:0]                ra;
   logic [3:0]                rb;
   logic                      fwd_a;
   logic                      fwd_b;
   logic [IDX_W-1:0]          rd_idx;

   assign exec_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec_fire;
   assign req_fire  = req_valid && req_ready;

   assign st.pc          = pc_ff;
   assign st.index       = index_ff;
   assign st.delay       = delay_ff;
   assign st.sound       = sound_ff;
   assign st.stack_full  = depth_ff == DEPTH_W'(STACK_DEPTH);
   assign st.stack_empty = depth_ff == '0;
   assign st.stack_top   = top_ff;

   c8ie_exec u_exec (
      .item (item_ff),
      .st   (st),
      .res  (ex)
   );

   // Register file read addresses; the indexed jump reads V0 on the second port
   assign ra = req_opcode[11:8];
   assign rb = (req_opcode[15:12] == c8ie_pkg::GRP_JP_V0) ? c8ie_pkg::REG_V0 : req_opcode[7:4];

   assign vf_in = (exec_fire && ex.vf_we) ? ex.vf_wdata : vf_ff;
   assign fwd_a = exec_fire && ex.rf_we && (ex.rf_waddr == ra);
   assign fwd_b = exec_fire && ex.rf_we && (ex.rf_waddr == rb);
   assign rd_idx = IDX_W'(depth_ff - DEPTH_W'(3));

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= c8ie_pkg::START_ADDRESS_RESET;
         index_ff     <= '0;
         delay_ff     <= '0;
         sound_ff     <= '0;
         depth_ff     <= '0;
         vf_ff        <= '0;
         rf_valid_ff  <= '0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            pc_ff <= csr_write_data;
         end else if (exec_fire) begin
            pc_ff <= ex.next_pc;
         end
         if (exec_fire) begin
            index_ff <= ex.index_next;
            delay_ff <= ex.delay_next;
            sound_ff <= ex.sound_next;
            vf_ff    <= vf_in;
            if (ex.push) depth_ff <= depth_ff + DEPTH_W'(1);
            if (ex.pop)  depth_ff <= depth_ff - DEPTH_W'(1);
            if (ex.rf_we) rf_valid_ff[ex.rf_waddr] <= 1'b1;
         end
      end
   end

   // Input register, with operand read and forwarding from the executing item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.command     <= req_command;
         item_ff.opcode      <= req_opcode;
         item_ff.random_byte <= req_random_byte;
         if (ra == c8ie_pkg::REG_FLAG)  item_ff.vx <= vf_in;
         else if (fwd_a)                item_ff.vx <= ex.rf_wdata;
         else if (rf_valid_ff[ra])      item_ff.vx <= rf_mem[ra];
         else                           item_ff.vx <= 8'd0;
         if (rb == c8ie_pkg::REG_FLAG)  item_ff.vb <= vf_in;
         else if (fwd_b)                item_ff.vb <= ex.rf_wdata;
         else if (rf_valid_ff[rb])      item_ff.vb <= rf_mem[rb];
         else                           item_ff.vb <= 8'd0;
      end
   end

   // V0..VE storage
   always_ff @(posedge clock) begin
      if (exec_fire && ex.rf_we) rf_mem[ex.rf_waddr] <= ex.rf_wdata;
   end

   // Return stack: top and next-to-top mirrored in registers so a pop takes its new top from a register
   always_ff @(posedge clock) begin
      if (exec_fire && ex.push) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= ex.push_addr;
         top_ff   <= ex.push_addr;
         below_ff <= top_ff;
      end else if (exec_fire && ex.pop) begin
         top_ff <= below_ff;
         if (depth_ff >= DEPTH_W'(3)) below_ff <= stack_mem[rd_idx];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (exec_fire) rsp_ff <= ex;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_ff.next_pc;
   assign rsp_index_value  = rsp_ff.index_next;
   assign rsp_reg_written  = rsp_ff.reg_written;
   assign rsp_reg_number   = rsp_ff.reg_number;
   assign rsp_reg_value    = rsp_ff.reg_value;
   assign rsp_clear_screen = rsp_ff.clear_screen;
   assign rsp_sound_on     = rsp_ff.sound_next != 8'd0;
   assign rsp_stack_error  = rsp_ff.stack_error;

endmodule
